@@ src/mbp_pkg.sv @@
// Shared constants and types of the MSB-first bit packer.
// Used by the front, queue, back and top modules; no dependencies.
`default_nettype none

package mbp_pkg;

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int DEF_MAX_FIELD_BITS = 32;
   localparam int DEF_COUNT_BITS     = 32;

   localparam int VALUE_BITS      = 32;
   localparam int WIDTH_BITS      = 6;
   localparam int BYTE_BITS       = 8;
   localparam int BITS_FIELD_BITS = 4;
   localparam int TOTAL_OUT_BITS  = 32;
   localparam int PEND_BITS       = 7;
   localparam int PCNT_BITS       = 3;
   localparam int NBYTES_BITS     = 3;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                   flush;
      logic [NBYTES_BITS-1:0] nbytes;
      logic [PCNT_BITS-1:0]   pend_count;
   } job_ctl_type;

endpackage

`default_nettype wire

@@ src/mbp_front.sv @@
// Front of the bit packer: accepts items, merges fields with pending bits,
// and posts byte jobs to the queue. Depends on mbp_pkg.
`default_nettype none

module mbp_front #(
   parameter int FIELD_LIMIT = 32,
   parameter int DATA_BITS   = 32,
   parameter int COUNT_BITS  = 32
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire                             req_opcode,
   input  wire [mbp_pkg::VALUE_BITS-1:0]   req_field_value,
   input  wire [mbp_pkg::WIDTH_BITS-1:0]   req_field_width,
   input  wire                             q_full,
   output logic                            job_write,
   output mbp_pkg::job_ctl_type            job_ctl,
   output logic [DATA_BITS-1:0]            job_data,
   output logic [COUNT_BITS-1:0]           job_start
);
   import mbp_pkg::*;

   localparam int ACC_BITS = FIELD_LIMIT + PEND_BITS;

   logic [PEND_BITS-1:0]  pend_ff, pend_in;
   logic [PCNT_BITS-1:0]  pcnt_ff, pcnt_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic                  accept;
   logic                  is_flush;
   logic [WIDTH_BITS-1:0] w_sat;
   logic [VALUE_BITS-1:0] masked;
   logic [ACC_BITS-1:0]   acc;
   logic [ACC_BITS-1:0]   aligned;
   logic [WIDTH_BITS-1:0] cnt;
   logic [BYTE_BITS-1:0]  fbyte;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_flush  = (req_opcode == OP_FLUSH);

   assign w_sat   = (req_field_width > WIDTH_BITS'(FIELD_LIMIT)) ?
                    WIDTH_BITS'(FIELD_LIMIT) : req_field_width;
   assign masked  = req_field_value & ~({VALUE_BITS{1'b1}} << w_sat);
   assign acc     = (ACC_BITS'(pend_ff) << w_sat) | ACC_BITS'(masked);
   assign cnt     = WIDTH_BITS'(pcnt_ff) + w_sat;
   assign aligned = acc << (WIDTH_BITS'(ACC_BITS) - cnt);
   assign fbyte   = BYTE_BITS'({1'b0, pend_ff} << (4'd8 - {1'b0, pcnt_ff}));

   always_comb begin
      job_ctl.flush      = is_flush;
      job_ctl.nbytes     = is_flush ? NBYTES_BITS'(1) : cnt[WIDTH_BITS-1:PCNT_BITS];
      job_ctl.pend_count = pcnt_ff;
      job_data  = is_flush ? (DATA_BITS'(fbyte) << (DATA_BITS - BYTE_BITS))
                           : aligned[ACC_BITS-1 -: DATA_BITS];
      job_start = is_flush ? total_ff : total_ff - COUNT_BITS'(pcnt_ff);
      job_write = accept && (is_flush || (cnt[WIDTH_BITS-1:PCNT_BITS] != '0));
   end

   always_comb begin
      pend_in  = pend_ff;
      pcnt_in  = pcnt_ff;
      total_in = total_ff;
      if (accept) begin
         if (is_flush) begin
            pend_in  = '0;
            pcnt_in  = '0;
            total_in = '0;
         end else begin
            pend_in  = acc[PEND_BITS-1:0] & ~({PEND_BITS{1'b1}} << cnt[PCNT_BITS-1:0]);
            pcnt_in  = cnt[PCNT_BITS-1:0];
            total_in = total_ff + COUNT_BITS'(w_sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         pcnt_ff  <= '0;
         total_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         pcnt_ff  <= pcnt_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

@@ src/mbp_queue.sv @@
// Short job queue between the front and back of the bit packer.
// Depth is a power of two from mbp_pkg; depends on mbp_pkg.
`default_nettype none

module mbp_queue #(
   parameter int ENTRY_BITS = 48
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_en,
   input  wire  [ENTRY_BITS-1:0] wr_data,
   output logic                  full,
   input  wire                   rd_en,
   output logic [ENTRY_BITS-1:0] rd_data,
   output logic                  not_empty
);
   import mbp_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [ENTRY_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [PTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = slot_ff[rptr_ff];
   assign do_wr     = wr_en && !full;
   assign do_rd     = rd_en && not_empty;

   always_comb begin
      wptr_in  = do_wr ? wptr_ff + PTR_BITS'(1) : wptr_ff;
      rptr_in  = do_rd ? rptr_ff + PTR_BITS'(1) : rptr_ff;
      count_in = count_ff + CNT_BITS'(do_wr) - CNT_BITS'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/mbp_back.sv @@
// Back of the bit packer: takes jobs from the queue and sends their bytes,
// one result item per cycle while rsp_ready is high, from registered outputs. Depends on mbp_pkg.
`default_nettype none

module mbp_back #(
   parameter int DATA_BITS  = 32,
   parameter int COUNT_BITS = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  job_valid,
   output logic                                 job_pop,
   input  wire  mbp_pkg::job_ctl_type           job_ctl,
   input  wire  [DATA_BITS-1:0]                 job_data,
   input  wire  [COUNT_BITS-1:0]                job_start,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [mbp_pkg::BYTE_BITS-1:0]        rsp_out_byte,
   output logic [mbp_pkg::BITS_FIELD_BITS-1:0]  rsp_byte_bits,
   output logic                                 rsp_run_last,
   output logic                                 rsp_buffer_end,
   output logic [mbp_pkg::TOTAL_OUT_BITS-1:0]   rsp_total_bits
);
   import mbp_pkg::*;

   logic                   valid_ff, valid_in;
   logic [NBYTES_BITS-1:0] left_ff, left_in;
   logic                   flush_ff, flush_in;
   logic [PCNT_BITS-1:0]   pcnt_ff, pcnt_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;
   logic                   last_beat;
   logic                   beat;

   assign last_beat = (left_ff == NBYTES_BITS'(1));
   assign beat      = valid_ff && rsp_ready;
   assign job_pop   = job_valid && (!valid_ff || (rsp_ready && last_beat));

   always_comb begin
      valid_in = valid_ff;
      left_in  = left_ff;
      flush_in = flush_ff;
      pcnt_in  = pcnt_ff;
      shift_in = shift_ff;
      total_in = total_ff;
      if (job_pop) begin
         valid_in = 1'b1;
         left_in  = job_ctl.nbytes;
         flush_in = job_ctl.flush;
         pcnt_in  = job_ctl.pend_count;
         shift_in = job_data;
         total_in = job_ctl.flush ? job_start : job_start + COUNT_BITS'(BYTE_BITS);
      end else if (beat) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            left_in  = left_ff - NBYTES_BITS'(1);
            shift_in = shift_ff << BYTE_BITS;
            total_in = total_ff + COUNT_BITS'(BYTE_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         left_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         left_ff  <= left_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      pcnt_ff  <= pcnt_in;
      shift_ff <= shift_in;
      total_ff <= total_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = shift_ff[DATA_BITS-1 -: BYTE_BITS];
   assign rsp_byte_bits  = flush_ff ? BITS_FIELD_BITS'(pcnt_ff) : BITS_FIELD_BITS'(BYTE_BITS);
   assign rsp_run_last   = last_beat;
   assign rsp_buffer_end = flush_ff;
   assign rsp_total_bits = TOTAL_OUT_BITS'(total_ff);

endmodule

`default_nettype wire

@@ src/msb_first_bit_packer_core.sv @@
// Top level of the MSB-first bit packer: front, job queue and back.
// Depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid/req_ready   | opcode, field_value, field_width
//   rsp_    | out       | rsp_valid/rsp_ready   | out_byte, byte_bits, run_last,
//           |           |                       | buffer_end, total_bits
//
// The front takes one item per cycle while the two-entry job queue has room.
// The back sends one result item per cycle while rsp_ready is high, so a push
// gives 1 to 4 items (one per completed byte) and a flush gives one; the output
// port sets the sustained rate. A push that completes no byte posts no job.
// Reset clears pending bits, the bit total, the queue and rsp_valid.
// A stalled output fills the queue, after which req_ready drops.
`default_nettype none

module msb_first_bit_packer_core #(
   parameter int MAX_FIELD_BITS = mbp_pkg::DEF_MAX_FIELD_BITS,
   parameter int COUNT_BITS     = mbp_pkg::DEF_COUNT_BITS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_opcode,
   input  wire  [mbp_pkg::VALUE_BITS-1:0]       req_field_value,
   input  wire  [mbp_pkg::WIDTH_BITS-1:0]       req_field_width,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [mbp_pkg::BYTE_BITS-1:0]        rsp_out_byte,
   output logic [mbp_pkg::BITS_FIELD_BITS-1:0]  rsp_byte_bits,
   output logic                                 rsp_run_last,
   output logic                                 rsp_buffer_end,
   output logic [mbp_pkg::TOTAL_OUT_BITS-1:0]   rsp_total_bits
);
   import mbp_pkg::*;

   localparam int FIELD_LIMIT = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
   localparam int DATA_BITS   = ((FIELD_LIMIT + PEND_BITS) / BYTE_BITS) * BYTE_BITS;
   localparam int CTL_BITS    = $bits(job_ctl_type);
   localparam int ENTRY_BITS  = CTL_BITS + DATA_BITS + COUNT_BITS;

   logic                  q_full;
   logic                  q_write;
   job_ctl_type           wr_ctl;
   logic [DATA_BITS-1:0]  wr_data;
   logic [COUNT_BITS-1:0] wr_start;
   logic [ENTRY_BITS-1:0] q_wr_entry;
   logic [ENTRY_BITS-1:0] q_rd_entry;
   logic                  q_not_empty;
   logic                  q_pop;
   job_ctl_type           rd_ctl;
   logic [DATA_BITS-1:0]  rd_data;
   logic [COUNT_BITS-1:0] rd_start;

   mbp_front #(
      .FIELD_LIMIT (FIELD_LIMIT),
      .DATA_BITS   (DATA_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_field_value (req_field_value),
      .req_field_width (req_field_width),
      .q_full          (q_full),
      .job_write       (q_write),
      .job_ctl         (wr_ctl),
      .job_data        (wr_data),
      .job_start       (wr_start)
   );

   assign q_wr_entry = {wr_ctl, wr_data, wr_start};

   mbp_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_write),
      .wr_data   (q_wr_entry),
      .full      (q_full),
      .rd_en     (q_pop),
      .rd_data   (q_rd_entry),
      .not_empty (q_not_empty)
   );

   assign rd_ctl   = q_rd_entry[ENTRY_BITS-1 -: CTL_BITS];
   assign rd_data  = q_rd_entry[DATA_BITS+COUNT_BITS-1 -: DATA_BITS];
   assign rd_start = q_rd_entry[COUNT_BITS-1:0];

   mbp_back #(
      .DATA_BITS  (DATA_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (q_not_empty),
      .job_pop        (q_pop),
      .job_ctl        (rd_ctl),
      .job_data       (rd_data),
      .job_start      (rd_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_bits  (rsp_byte_bits),
      .rsp_run_last   (rsp_run_last),
      .rsp_buffer_end (rsp_buffer_end),
      .rsp_total_bits (rsp_total_bits)
   );

`ifndef NO_ASSERTIONS
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_buffer_end |-> rsp_run_last)
      else $error("buffer end item not marked as last of its run");

   a_push_full_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_buffer_end |-> rsp_byte_bits == BITS_FIELD_BITS'(BYTE_BITS))
      else $error("push result item without a full byte");

   a_run_advances: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=>
         rsp_valid && !rsp_buffer_end &&
         (rsp_total_bits[7:0] == $past(rsp_total_bits[7:0]) + 8'd8))
      else $error("run broken or bit total not advanced by one byte");
`endif

endmodule

`default_nettype wire
